// ===== src/sorted_insert_priority_queue_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define SIPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SIPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sipq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue - package
// Opcodes, status codes and the cell control group.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== src/sipq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue - queue cell
// Holds one entry; on insert keeps, takes the new entry or takes its left
// neighbour's entry, on remove takes its right neighbour's entry.
// ----------------------------------------------------------------------------
module sipq_cell
    import sipq_pkg::*;
#(
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8,
    parameter bit FIRST    = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic                i_prev_before,
    input  logic                i_prev_valid,
    input  logic [KEY_BITS-1:0] i_prev_key,
    input  logic [TAG_BITS-1:0] i_prev_tag,
    input  logic                i_next_valid,
    input  logic [KEY_BITS-1:0] i_next_key,
    input  logic [TAG_BITS-1:0] i_next_tag,
    output logic                o_before,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_key,
    output logic [TAG_BITS-1:0] o_tag
);

    logic                r_valid, n_valid;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                keep;

    // front entry stays ahead of an equal new key
    assign keep = r_valid && (FIRST ? (r_key <= i_key) : (r_key < i_key));

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_ctl.ins) begin
            if (!keep) begin
                if (i_prev_before) begin
                    n_valid = 1'b1;
                    n_key   = i_key;
                    n_tag   = i_tag;
                end else begin
                    n_valid = i_prev_valid;
                    n_key   = i_prev_key;
                    n_tag   = i_prev_tag;
                end
            end
        end else if (i_ctl.rem) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
            n_tag   = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_before = keep;
    assign o_valid  = r_valid;
    assign o_key    = r_key;
    assign o_tag    = r_tag;

endmodule

// ===== src/sorted_insert_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue - top level
// Bounded queue in ascending key order, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. busy
//   is always low: every cell compares the new key and shifts in the same
//   cycle, so one request is taken per clock, back to back.
//   i_opcode selects insert (i_key_in, i_tag_in) or remove of the front.
//   Each request gives one result in the cycle after it is taken: o_done is high
//   for that single cycle with o_status, o_front_key, o_front_tag, o_is_empty
//   and o_entry_count describing the queue after the request.
//   Throughput 1 request per cycle, set by the cell row's compare and shift.
//   An insert into a full queue is dropped (status full); a remove on an
//   empty queue changes nothing (status empty). Front key and tag read 0
//   when the queue is empty.
//   Reset empties the queue at once; no clearing pass is needed.
//   The receiver cannot stall: results must be taken in their cycle.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_top
    import sipq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [KEY_BITS-1:0]          i_key_in,
    input  logic [TAG_BITS-1:0]          i_tag_in,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [KEY_BITS-1:0]          o_front_key,
    output logic [TAG_BITS-1:0]          o_front_tag,
    output logic                         o_is_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic                r_done;
    t_status             r_status, n_status;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                accept, full, empty;
    t_cell_ctl           ctl;

    logic [DEPTH-1:0]    keep;
    logic [DEPTH-1:0]    valid;
    logic [KEY_BITS-1:0] key [DEPTH];
    logic [TAG_BITS-1:0] tag [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_BITS'(DEPTH));
    assign empty  = (r_count == '0);

    always_comb begin
        ctl      = '0;
        n_status = ST_DONE;
        n_count  = r_count;
        if (accept) begin
            if (i_opcode == OP_INSERT) begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.ins = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end else begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctl.rem = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                p_before, p_valid, x_valid;
        logic [KEY_BITS-1:0] p_key, x_key;
        logic [TAG_BITS-1:0] p_tag, x_tag;

        if (g == 0) begin : g_head
            assign p_before = 1'b1;
            assign p_valid  = 1'b0;
            assign p_key    = '0;
            assign p_tag    = '0;
        end else begin : g_body
            assign p_before = keep[g-1];
            assign p_valid  = valid[g-1];
            assign p_key    = key[g-1];
            assign p_tag    = tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign x_valid = 1'b0;
            assign x_key   = '0;
            assign x_tag   = '0;
        end else begin : g_link
            assign x_valid = valid[g+1];
            assign x_key   = key[g+1];
            assign x_tag   = tag[g+1];
        end

        sipq_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS),
            .FIRST    (g == 0)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_key         (i_key_in),
            .i_tag         (i_tag_in),
            .i_prev_before (p_before),
            .i_prev_valid  (p_valid),
            .i_prev_key    (p_key),
            .i_prev_tag    (p_tag),
            .i_next_valid  (x_valid),
            .i_next_key    (x_key),
            .i_next_tag    (x_tag),
            .o_before      (keep[g]),
            .o_valid       (valid[g]),
            .o_key         (key[g]),
            .o_tag         (tag[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_status <= ST_DONE;
            r_count  <= '0;
        end else begin
            r_done   <= accept;
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_front_key   = valid[0] ? key[0] : '0;
    assign o_front_tag   = valid[0] ? tag[0] : '0;
    assign o_is_empty    = empty;
    assign o_entry_count = r_count;

endmodule

// ===== src/sipq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted insert priority queue - port checker
// Watches the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
`include "sorted_insert_priority_queue_top_defines.svh"

module sipq_port_checker
    import sipq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic [1:0]                 o_status,
    input logic [KEY_BITS-1:0]        o_front_key,
    input logic [TAG_BITS-1:0]        o_front_tag,
    input logic                       o_is_empty,
    input logic [$clog2(DEPTH+1)-1:0] o_entry_count
);

    `SIPQ_ASSERT_NEXT(a_done_follows, start && !busy, o_done, "request without result")
    `SIPQ_ASSERT_NEXT(a_no_spurious, !(start && !busy), !o_done, "result without request")
    `SIPQ_ASSERT_NOW(a_empty_front, o_done && o_is_empty, o_front_key == '0 && o_front_tag == '0, "front not cleared when empty")
    `SIPQ_ASSERT_NOW(a_empty_count, o_done, o_is_empty == (o_entry_count == '0), "empty flag disagrees with count")
    `SIPQ_ASSERT_NOW(a_full_count, o_done && o_status == ST_FULL, o_entry_count == ($clog2(DEPTH+1))'(DEPTH), "full status below capacity")

endmodule

bind sorted_insert_priority_queue_top sipq_port_checker #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
) u_sipq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_front_key   (o_front_key),
    .o_front_tag   (o_front_tag),
    .o_is_empty    (o_is_empty),
    .o_entry_count (o_entry_count)
);

// ===== bench/sipq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted insert priority queue - result checker
// Watches the request and result ports of the queue and keeps its own
// sorted copy of the queue contents. Each accepted request is applied to
// that copy. The outcome it gives is queued and compared field by field
// with the next result the block strobes out.
// ----------------------------------------------------------------------------
module sipq_checker
    import sipq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8,
    parameter int CNT_BITS = $clog2(DEPTH+1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic                i_opcode,
    input  logic [KEY_BITS-1:0] i_key_in,
    input  logic [TAG_BITS-1:0] i_tag_in,
    input  logic                i_done,
    input  logic [1:0]          i_status,
    input  logic [KEY_BITS-1:0] i_front_key,
    input  logic [TAG_BITS-1:0] i_front_tag,
    input  logic                i_is_empty,
    input  logic [CNT_BITS-1:0] i_entry_count,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count,
    output int                  o_full_count,
    output int                  o_empty_count
);

    typedef struct {
        t_status             status;
        logic [KEY_BITS-1:0] front_key;
        logic [TAG_BITS-1:0] front_tag;
        logic                is_empty;
        logic [CNT_BITS-1:0] count;
    } t_outcome;

    logic [KEY_BITS-1:0] queue_keys [DEPTH];
    logic [TAG_BITS-1:0] queue_tags [DEPTH];
    int                  queue_fill;
    t_outcome            outcome_fifo [$];
    t_outcome            want;
    t_outcome            next_outcome;

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
        o_full_count   = 0;
        o_empty_count  = 0;
        queue_fill     = 0;
    end

    assign o_pending = outcome_fifo.size();

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("mismatch at result %0d: %s = %0h, expected %0h",
                 o_result_count, what, got, exp_val);
        o_fail_count++;
    endtask

    task automatic apply_request(input logic op, input logic [KEY_BITS-1:0] k,
                                 input logic [TAG_BITS-1:0] t, output t_outcome res);
        int pos;
        int i;
        res.status = ST_DONE;
        if (op == OP_INSERT) begin
            if (queue_fill >= DEPTH) begin
                res.status = ST_FULL;
                o_full_count++;
            end else begin
                // equal keys: after an equal front, ahead of later equals
                if (queue_fill == 0 || queue_keys[0] > k) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < queue_fill && queue_keys[pos] < k) pos++;
                end
                for (i = queue_fill; i > pos; i--) begin
                    queue_keys[i] = queue_keys[i-1];
                    queue_tags[i] = queue_tags[i-1];
                end
                queue_keys[pos] = k;
                queue_tags[pos] = t;
                queue_fill++;
            end
        end else begin
            if (queue_fill == 0) begin
                res.status = ST_EMPTY;
                o_empty_count++;
            end else begin
                for (i = 0; i + 1 < queue_fill; i++) begin
                    queue_keys[i] = queue_keys[i+1];
                    queue_tags[i] = queue_tags[i+1];
                end
                queue_fill--;
            end
        end
        if (queue_fill == 0) begin
            res.front_key = '0;
            res.front_tag = '0;
            res.is_empty  = 1'b1;
        end else begin
            res.front_key = queue_keys[0];
            res.front_tag = queue_tags[0];
            res.is_empty  = 1'b0;
        end
        res.count = CNT_BITS'(queue_fill);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            queue_fill = 0;
            outcome_fifo.delete();
        end else begin
            if (i_done) begin
                if (outcome_fifo.size() == 0) begin
                    report_mismatch("result with no request", 1, 0);
                end else begin
                    want = outcome_fifo.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_front_key !== want.front_key)
                        report_mismatch("front_key", i_front_key, want.front_key);
                    if (i_front_tag !== want.front_tag)
                        report_mismatch("front_tag", i_front_tag, want.front_tag);
                    if (i_is_empty !== want.is_empty)
                        report_mismatch("is_empty", i_is_empty, want.is_empty);
                    if (i_entry_count !== want.count)
                        report_mismatch("entry_count", i_entry_count, want.count);
                end
                o_result_count++;
            end
            if (i_start && !i_busy) begin
                apply_request(i_opcode, i_key_in, i_tag_in, next_outcome);
                outcome_fifo.push_back(next_outcome);
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted insert priority queue - testbench top
// Drives insert and remove requests into the queue: a directed run over
// equal keys, key extremes, a full queue and an empty queue, then random
// fill and drain episodes under three sender idle rates. The checker
// predicts and compares every result; a watchdog ends a stalled run.
// ----------------------------------------------------------------------------
module tb_top;
    import sipq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 16;
    localparam int TAG_BITS   = 8;
    localparam int CNT_BITS   = $clog2(DEPTH+1);
    localparam int PHASE_REQS = 534;
    localparam int STALL_MAX  = 1000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_opcode;
    logic [KEY_BITS-1:0] i_key_in;
    logic [TAG_BITS-1:0] i_tag_in;
    logic                o_done;
    logic [1:0]          o_status;
    logic [KEY_BITS-1:0] o_front_key;
    logic [TAG_BITS-1:0] o_front_tag;
    logic                o_is_empty;
    logic [CNT_BITS-1:0] o_entry_count;

    int fail_count;
    int pending;
    int result_count;
    int full_count;
    int empty_count;
    int accepted;
    int stall_cycles;
    int idle_pct;

    sorted_insert_priority_queue_top #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_key_in      (i_key_in),
        .i_tag_in      (i_tag_in),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_front_key   (o_front_key),
        .o_front_tag   (o_front_tag),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count)
    );

    sipq_checker #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (i_opcode),
        .i_key_in       (i_key_in),
        .i_tag_in       (i_tag_in),
        .i_done         (o_done),
        .i_status       (o_status),
        .i_front_key    (o_front_key),
        .i_front_tag    (o_front_tag),
        .i_is_empty     (o_is_empty),
        .i_entry_count  (o_entry_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_full_count   (full_count),
        .o_empty_count  (empty_count)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_done)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (i_rst_n && start && !busy) accepted <= accepted + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("watchdog: no request or result for %0d cycles", STALL_MAX);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [KEY_BITS-1:0] k,
                                input logic [TAG_BITS-1:0] t);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_opcode <= op;
        i_key_in <= k;
        i_tag_in <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return KEY_BITS'($urandom_range(0, 7));
            1: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return {1'b1, {(KEY_BITS-1){1'b0}}};
                    default: return {1'b0, {(KEY_BITS-1){1'b1}}};
                endcase
            end
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    logic [KEY_BITS-1:0] fill_keys [12] = '{
        16'h8000, 16'h8000, 16'h7fff, 16'h0001, 16'hfffe, 16'hffff,
        16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h1234, 16'h8001
    };

    initial begin
        int phase;
        int n;
        int ins_pct;
        start        <= 1'b0;
        i_opcode     <= OP_INSERT;
        i_key_in     <= '0;
        i_tag_in     <= '0;
        i_rst_n      <= 1'b0;
        accepted     <= 0;
        stall_cycles <= 0;
        idle_pct     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty remove, extremes, equal keys at and behind the front,
        // fill to the limit, insert on full, then drain a little
        send_request(OP_REMOVE, '1, '1);
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, '0, 8'ha5);
        send_request(OP_INSERT, '0, 8'h5a);
        send_request(OP_REMOVE, '0, '0);
        send_request(OP_INSERT, '0, 8'hc3);
        for (n = 0; n < 12; n++) send_request(OP_INSERT, fill_keys[n], TAG_BITS'(n + 1));
        send_request(OP_INSERT, 16'h4000, 8'h77);
        send_request(OP_REMOVE, '0, '0);
        send_request(OP_INSERT, '1, 8'h3c);
        repeat (3) send_request(OP_REMOVE, '1, '1);

        // random fill and drain episodes under idle rates of 20, 50 and 0 percent
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 20 : (phase == 1) ? 50 : 0;
            ins_pct  = 50;
            for (n = 0; n < PHASE_REQS; n++) begin
                if (n % 32 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       ins_pct = 85;
                        1:       ins_pct = 50;
                        default: ins_pct = 15;
                    endcase
                end
                send_request(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                             pick_key(), TAG_BITS'($urandom));
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d requests taken, %0d results checked", accepted, result_count);
        $display("%0d inserts dropped on a full queue, %0d removes on an empty queue",
                 full_count, empty_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
